[sv/tts_pkg.sv]
// Shared types and constants for the text terminal scroll engine.
// Holds screen geometry, character codes, function codes and controller types.
// No dependencies.
package tts_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int POS_W      = 12;
	localparam int IDX_W      = 11;
	localparam int CELL_W     = 16;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] RESET_COLOUR = 8'd31;

	typedef enum logic [1:0] {
		FN_PUT    = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_PUT_AT = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_CLEAR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [CELL_W-1:0] rd;
		logic              err;
		logic [IDX_W-1:0]  idx;
	} resp_t;

endpackage

[sv/tts_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/tts_ctrl.sv]
// Controller for the text terminal: cursor, sequencer and screen RAM port control.
// Runs the reset clearing pass, clear and scroll sweeps. Depends on tts_pkg.
module tts_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  func,
	input  logic [7:0]                  character,
	input  logic [7:0]                  cell_colour,
	input  logic [6:0]                  column_in,
	input  logic [4:0]                  row_in,
	input  logic [7:0]                  text_colour,
	output logic                        busy,
	output logic                        ram_we,
	output logic [tts_pkg::ADDR_W-1:0]  ram_waddr,
	output logic [tts_pkg::CELL_W-1:0]  ram_wdata,
	output logic [tts_pkg::ADDR_W-1:0]  ram_raddr,
	input  logic [tts_pkg::CELL_W-1:0]  ram_rdata,
	output tts_pkg::resp_t              resp
);
	import tts_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   cnt_q, cnt_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [CELL_W-1:0]   rd_q, rd_d;
	logic                err_q, err_d;

	logic [POS_W-1:0]    pos_full;
	logic [POS_W-1:0]    cur_full;
	logic [ADDR_W-1:0]   pos_addr;
	logic [ADDR_W-1:0]   cur_addr;
	logic                on_screen;
	logic [CELL_W-1:0]   blank;

	assign pos_full  = POS_W'(row_in) * POS_W'(COLUMNS) + POS_W'(column_in);
	assign cur_full  = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	assign pos_addr  = pos_full[ADDR_W-1:0];
	assign cur_addr  = cur_full[ADDR_W-1:0];
	assign on_screen = (32'(column_in) < COLUMNS) && (32'(row_in) < ROWS);
	assign blank     = {text_colour, SPACE_CHAR};
	assign busy      = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		row_d      = row_q;
		col_d      = col_q;
		rd_d       = rd_q;
		err_d      = err_q;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q;
		ram_wdata  = blank;
		ram_raddr  = pos_addr;
		resp.valid = 1'b0;
		resp.rd    = rd_q;
		resp.err   = err_q;
		resp.idx   = cur_full[IDX_W-1:0];

		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {RESET_COLOUR, SPACE_CHAR};
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					rd_d  = '0;
					err_d = 1'b0;
					case (func_t'(func))
						FN_PUT: begin
							state_d = ST_RESP;
							if (character != NEWLINE_CHAR) begin
								ram_we    = 1'b1;
								ram_waddr = cur_addr;
								ram_wdata = {text_colour, character};
							end
							if (character != NEWLINE_CHAR && col_q != LAST_COL) begin
								col_d = col_q + 1'b1;
							end else begin
								// wrap or newline: column 0 of the next row
								col_d = '0;
								if (row_q == LAST_ROW) begin
									cnt_d   = '0;
									state_d = ST_SCROLL;
								end else begin
									row_d = row_q + 1'b1;
								end
							end
						end
						FN_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_CLEAR;
						end
						FN_PUT_AT: begin
							state_d = ST_RESP;
							if (on_screen) begin
								ram_we    = 1'b1;
								ram_waddr = pos_addr;
								ram_wdata = {cell_colour, character};
							end else begin
								err_d = 1'b1;
							end
						end
						FN_READ: begin
							if (on_screen) begin
								state_d = ST_READ;
							end else begin
								err_d   = 1'b1;
								state_d = ST_RESP;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_READ: begin
				rd_d    = ram_rdata;
				state_d = ST_RESP;
			end
			ST_SCROLL: begin
				// read one row ahead, write back the cell fetched last cycle
				ram_raddr = cnt_q + ROW_STEP;
				if (cnt_q != '0) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q - 1'b1;
					ram_wdata = ram_rdata;
				end
				if (cnt_q == COPY_END) begin
					state_d = ST_CLEAR;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = '0;
					state_d = ST_RESP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_RESP: begin
				resp.valid = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_q  <= rd_d;
		err_q <= err_d;
	end

endmodule

[sv/text_terminal_scroll_engine_unit.sv]
// Put, put-at and error items go from start through the response state to done, a read
// through a read state first; clear and scroll walk the screen RAM one cell a cycle.
// One transaction at a time; busy drops as done rises.
// Reset: a clearing pass over all ROWS*COLUMNS cells (2000) fills the screen with blanks;
// busy stays high until it ends. Results cannot be stalled by the receiver.
// Top level: colour register, controller, screen RAM and result registers.
module text_terminal_scroll_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  character,
	input  logic [7:0]  cell_colour,
	input  logic [6:0]  column_in,
	input  logic [4:0]  row_in,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [15:0] read_data,
	output logic [10:0] cursor_index,
	output logic        position_error
);
	import tts_pkg::*;

	logic [7:0]        text_colour_q;
	logic              done_q;
	logic [CELL_W-1:0] read_data_q;
	logic [IDX_W-1:0]  cursor_index_q;
	logic              position_error_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	resp_t             resp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_colour_q <= RESET_COLOUR;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_colour_q <= cfg_data;
			end
			done_q <= resp.valid;
		end
	end

	// hold the transaction's result from its single strobe cycle until the next result
	always_ff @(posedge clk) begin
		if (resp.valid) begin
			read_data_q      <= resp.rd;
			cursor_index_q   <= resp.idx;
			position_error_q <= resp.err;
		end
	end

	tts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.character   (character),
		.cell_colour (cell_colour),
		.column_in   (column_in),
		.row_in      (row_in),
		.text_colour (text_colour_q),
		.busy        (busy),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.resp        (resp)
	);

	tts_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done           = done_q;
	assign read_data      = read_data_q;
	assign cursor_index   = cursor_index_q;
	assign position_error = position_error_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high in two consecutive cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && position_error) |-> (read_data == '0))
		else $error("position error with nonzero read data");
`endif

endmodule
